// ===== hdl/mpdm_pkg.sv =====
// Shared constants and types of the multi-pattern DNA match counter.
`default_nettype none
package mpdm_pkg;

    localparam int MAX_NODES_DEF = 65536;
    localparam int ALPHABET      = 4;
    localparam int SYM_W         = 2;
    localparam int TOTAL_WIDTH   = 48;
    localparam int COUNT_W       = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PATTERN = 2'd1,
        CMD_BUILD   = 2'd2,
        CMD_TEXT    = 2'd3
    } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/multi_pattern_dna_match_counter_unit.sv =====
// A clear zeroes the root; a pattern symbol follows or adds a child; a text symbol follows failure links.
// Build walks the trie breadth first, node by node, and follows failure links for each child.
// Transactions are taken one at a time; every step shares the child, node and queue RAM ports.
// A result waits in an output register while the next transaction is already taken.
// Reset: asynchronous, active low; an init pass then zeroes the root, with item_stall high.
`default_nettype none
module multi_pattern_dna_match_counter_unit
    import mpdm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire logic [1:0]             cmd,
    input  wire logic [SYM_W-1:0]       symbol,
    input  wire logic                   last,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [TOTAL_WIDTH-1:0]      match_total,
    output logic                        status,
    output logic                        text_done
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int ND_W = NW + 1 + COUNT_W;
    localparam int CH_D = MAX_NODES * ALPHABET;

    typedef enum logic [25:0] {
        ST_IDLE    = 26'h0000001,
        ST_INIT    = 26'h0000002,
        ST_CLR     = 26'h0000004,
        ST_P_START = 26'h0000008,
        ST_P_CHILD = 26'h0000010,
        ST_P_ZERO  = 26'h0000020,
        ST_P_END   = 26'h0000040,
        ST_P_MARK  = 26'h0000080,
        ST_B_START = 26'h0000100,
        ST_B_POP   = 26'h0000200,
        ST_B_X     = 26'h0000400,
        ST_B_XN    = 26'h0000800,
        ST_B_CH    = 26'h0001000,
        ST_B_Y     = 26'h0002000,
        ST_B_W     = 26'h0004000,
        ST_B_WC    = 26'h0008000,
        ST_B_WF    = 26'h0010000,
        ST_B_FSET  = 26'h0020000,
        ST_B_FC    = 26'h0040000,
        ST_B_YE    = 26'h0080000,
        ST_T_RD    = 26'h0100000,
        ST_T_C     = 26'h0200000,
        ST_T_F     = 26'h0400000,
        ST_T_CNT   = 26'h0800000,
        ST_T_ADD   = 26'h1000000,
        ST_FIN     = 26'h2000000
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic                   last_reg, last_next;
    logic [CW-1:0]          nodes_used_reg, nodes_used_next;
    logic [NW-1:0]          ins_reg, ins_next;
    logic [NW-1:0]          scan_reg, scan_next;
    logic [TOTAL_WIDTH-1:0] total_reg, total_next;
    logic                   broken_reg, broken_next;
    logic                   status_reg, status_next;
    logic [NW-1:0]          x_reg, x_next;
    logic [NW-1:0]          xf_reg, xf_next;
    logic [NW-1:0]          w_reg, w_next;
    logic [NW-1:0]          y_reg, y_next;
    logic [NW-1:0]          f_reg, f_next;
    logic [COUNT_W-1:0]     fcount_reg, fcount_next;
    logic [SYM_W-1:0]       k_reg, k_next;
    logic [CW-1:0]          head_reg, head_next;
    logic [CW-1:0]          tail_reg, tail_next;
    logic                   rv_reg, rv_next;
    logic [TOTAL_WIDTH-1:0] mt_reg, mt_next;
    logic                   st_out_reg, st_out_next;
    logic                   td_reg, td_next;

    logic                   ch_we;
    logic [NW+SYM_W-1:0]    ch_waddr, ch_raddr;
    logic [NW-1:0]          ch_wdata, ch_rdata;
    logic                   nd_we;
    logic [NW-1:0]          nd_waddr, nd_raddr;
    logic [ND_W-1:0]        nd_wdata, nd_rdata;
    logic                   q_we;
    logic [NW-1:0]          q_waddr, q_raddr;
    logic [NW-1:0]          q_wdata, q_rdata;

    logic [NW-1:0]          nd_fail;
    logic                   nd_end;
    logic [COUNT_W-1:0]     nd_count;
    logic [COUNT_W:0]       cnt_sum;
    logic [COUNT_W-1:0]     cnt_sat;
    logic [TOTAL_WIDTH:0]   tot_sum;
    logic                   out_free;

    mpdm_ram #(.WIDTH(NW), .DEPTH(CH_D)) u_child_ram (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    mpdm_ram #(.WIDTH(ND_W), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .raddr (nd_raddr),
        .rdata (nd_rdata)
    );

    mpdm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign nd_fail  = nd_rdata[ND_W-1 -: NW];
    assign nd_end   = nd_rdata[COUNT_W];
    assign nd_count = nd_rdata[COUNT_W-1:0];
    assign cnt_sum  = {1'b0, fcount_reg} + {{COUNT_W{1'b0}}, nd_end};
    assign cnt_sat  = cnt_sum[COUNT_W] ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];
    assign tot_sum  = {1'b0, total_reg} + {{(TOTAL_WIDTH+1-COUNT_W){1'b0}}, nd_count};
    assign out_free = !rv_reg || !result_stall;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        nodes_used_next = nodes_used_reg;
        ins_next        = ins_reg;
        scan_next       = scan_reg;
        total_next      = total_reg;
        broken_next     = broken_reg;
        status_next     = status_reg;
        x_next          = x_reg;
        xf_next         = xf_reg;
        w_next          = w_reg;
        y_next          = y_reg;
        f_next          = f_reg;
        fcount_next     = fcount_reg;
        k_next          = k_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        rv_next         = rv_reg && result_stall;
        mt_next         = mt_reg;
        st_out_next     = st_out_reg;
        td_next         = td_reg;
        ch_we           = 1'b0;
        ch_waddr        = '0;
        ch_wdata        = '0;
        ch_raddr        = '0;
        nd_we           = 1'b0;
        nd_waddr        = '0;
        nd_wdata        = '0;
        nd_raddr        = '0;
        q_we            = 1'b0;
        q_waddr         = '0;
        q_wdata         = '0;
        q_raddr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next    = cmd_t'(cmd);
                    sym_next    = symbol;
                    last_next   = last;
                    status_next = 1'b0;
                    k_next      = '0;
                    x_next      = scan_reg;
                    unique case (cmd_t'(cmd))
                        CMD_CLEAR:   state_next = ST_CLR;
                        CMD_PATTERN: state_next = ST_P_START;
                        CMD_BUILD:   state_next = ST_B_START;
                        CMD_TEXT:    state_next = ST_T_RD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT, ST_CLR:
            begin
                ch_we    = 1'b1;
                ch_waddr = {{NW{1'b0}}, k_reg};
                nd_we    = 1'b1;
                k_next   = k_reg + 1'b1;
                if (k_reg == SYM_W'(ALPHABET - 1))
                begin
                    if (state_reg == ST_INIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        nodes_used_next = CW'(1);
                        ins_next        = '0;
                        scan_next       = '0;
                        total_next      = '0;
                        broken_next     = 1'b0;
                        state_next      = ST_FIN;
                    end
                end
            end
            ST_P_START:
            begin
                ch_raddr = {ins_reg, sym_reg};
                if (broken_reg)
                begin
                    status_next = 1'b1;
                    state_next  = ST_P_END;
                end
                else
                begin
                    state_next = ST_P_CHILD;
                end
            end
            ST_P_CHILD:
            begin
                if (ch_rdata != '0)
                begin
                    ins_next   = ch_rdata;
                    state_next = ST_P_END;
                end
                else if (nodes_used_reg == CW'(MAX_NODES))
                begin
                    broken_next = 1'b1;
                    status_next = 1'b1;
                    state_next  = ST_P_END;
                end
                else
                begin
                    ch_we           = 1'b1;
                    ch_waddr        = {ins_reg, sym_reg};
                    ch_wdata        = nodes_used_reg[NW-1:0];
                    y_next          = nodes_used_reg[NW-1:0];
                    ins_next        = nodes_used_reg[NW-1:0];
                    nodes_used_next = nodes_used_reg + 1'b1;
                    k_next          = '0;
                    state_next      = ST_P_ZERO;
                end
            end
            ST_P_ZERO:
            begin
                ch_we    = 1'b1;
                ch_waddr = {y_reg, k_reg};
                nd_we    = 1'b1;
                nd_waddr = y_reg;
                k_next   = k_reg + 1'b1;
                if (k_reg == SYM_W'(ALPHABET - 1))
                begin
                    state_next = ST_P_END;
                end
            end
            ST_P_END:
            begin
                nd_raddr = ins_reg;
                if (last_reg && !broken_reg)
                begin
                    state_next = ST_P_MARK;
                end
                else
                begin
                    if (last_reg)
                    begin
                        ins_next    = '0;
                        broken_next = 1'b0;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_P_MARK:
            begin
                nd_we      = 1'b1;
                nd_waddr   = ins_reg;
                nd_wdata   = {nd_fail, 1'b1, nd_count};
                ins_next   = '0;
                state_next = ST_FIN;
            end
            ST_B_START:
            begin
                q_we       = 1'b1;
                head_next  = '0;
                tail_next  = CW'(1);
                state_next = ST_B_POP;
            end
            ST_B_POP:
            begin
                q_raddr = head_reg[NW-1:0];
                if (head_reg == tail_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_B_X;
                end
            end
            ST_B_X:
            begin
                x_next     = q_rdata;
                nd_raddr   = q_rdata;
                k_next     = '0;
                state_next = ST_B_XN;
            end
            ST_B_XN:
            begin
                xf_next    = nd_fail;
                state_next = ST_B_CH;
            end
            ST_B_CH:
            begin
                ch_raddr   = {x_reg, k_reg};
                state_next = ST_B_Y;
            end
            ST_B_Y:
            begin
                if (ch_rdata == '0)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg == SYM_W'(ALPHABET - 1)) ? ST_B_POP : ST_B_CH;
                end
                else
                begin
                    y_next = ch_rdata;
                    if (x_reg == '0)
                    begin
                        f_next     = '0;
                        state_next = ST_B_FSET;
                    end
                    else
                    begin
                        w_next     = xf_reg;
                        state_next = ST_B_W;
                    end
                end
            end
            ST_B_W:
            begin
                ch_raddr   = {w_reg, k_reg};
                state_next = ST_B_WC;
            end
            ST_B_WC:
            begin
                nd_raddr = w_reg;
                if (ch_rdata != '0 || w_reg == '0)
                begin
                    f_next     = (ch_rdata == y_reg) ? '0 : ch_rdata;
                    state_next = ST_B_FSET;
                end
                else
                begin
                    state_next = ST_B_WF;
                end
            end
            ST_B_WF:
            begin
                w_next     = nd_fail;
                state_next = ST_B_W;
            end
            ST_B_FSET:
            begin
                nd_raddr   = f_reg;
                state_next = ST_B_FC;
            end
            ST_B_FC:
            begin
                fcount_next = nd_count;
                nd_raddr    = y_reg;
                state_next  = ST_B_YE;
            end
            ST_B_YE:
            begin
                nd_we      = 1'b1;
                nd_waddr   = y_reg;
                nd_wdata   = {f_reg, nd_end, cnt_sat};
                q_we       = 1'b1;
                q_waddr    = tail_reg[NW-1:0];
                q_wdata    = y_reg;
                tail_next  = tail_reg + 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = (k_reg == SYM_W'(ALPHABET - 1)) ? ST_B_POP : ST_B_CH;
            end
            ST_T_RD:
            begin
                ch_raddr   = {x_reg, sym_reg};
                state_next = ST_T_C;
            end
            ST_T_C:
            begin
                nd_raddr = x_reg;
                if (ch_rdata != '0)
                begin
                    x_next     = ch_rdata;
                    state_next = ST_T_CNT;
                end
                else if (x_reg == '0)
                begin
                    state_next = ST_T_CNT;
                end
                else
                begin
                    state_next = ST_T_F;
                end
            end
            ST_T_F:
            begin
                x_next     = nd_fail;
                state_next = ST_T_RD;
            end
            ST_T_CNT:
            begin
                nd_raddr   = x_reg;
                state_next = ST_T_ADD;
            end
            ST_T_ADD:
            begin
                total_next = tot_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}}
                                                  : tot_sum[TOTAL_WIDTH-1:0];
                scan_next  = x_reg;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    rv_next     = 1'b1;
                    mt_next     = total_reg;
                    st_out_next = status_reg;
                    td_next     = (cmd_reg == CMD_TEXT) && last_reg;
                    if ((cmd_reg == CMD_TEXT) && last_reg)
                    begin
                        scan_next  = '0;
                        total_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            nodes_used_reg <= CW'(1);
            ins_reg        <= '0;
            scan_reg       <= '0;
            total_reg      <= '0;
            broken_reg     <= 1'b0;
            k_reg          <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            ins_reg        <= ins_next;
            scan_reg       <= scan_next;
            total_reg      <= total_next;
            broken_reg     <= broken_next;
            k_reg          <= k_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            rv_reg         <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        x_reg      <= x_next;
        xf_reg     <= xf_next;
        w_reg      <= w_next;
        y_reg      <= y_next;
        f_reg      <= f_next;
        fcount_reg <= fcount_next;
        mt_reg     <= mt_next;
        st_out_reg <= st_out_next;
        td_reg     <= td_next;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign match_total  = mt_reg;
    assign status       = st_out_reg;
    assign text_done    = td_reg;

`ifndef SYNTHESIS
    a_ins_exists: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(ins_reg) < nodes_used_reg)
        else $error("insert node beyond allocated nodes");

    a_scan_exists: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(scan_reg) < nodes_used_reg)
        else $error("scan node beyond allocated nodes");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_B_POP) |-> (head_reg <= tail_reg && tail_reg <= nodes_used_reg))
        else $error("breadth-first queue pointers out of order");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free && cmd_reg == CMD_TEXT && last_reg)
        |=> (total_reg == '0 && scan_reg == '0))
        else $error("end of text did not restart the scan");
`endif

endmodule
`default_nettype wire

// ===== hdl/mpdm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule
`default_nettype wire

// ===== tb/multi_pattern_dna_match_counter_unit_tb.sv =====
// Self-checking testbench for the DNA match counter: random stimulus, automaton predictor.
module multi_pattern_dna_match_counter_unit_tb;
    import mpdm_pkg::*;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] sym;
        logic       lst;
    } item_t;

    typedef struct packed {
        logic [TOTAL_WIDTH-1:0] total;
        logic                   status;
        logic                   done;
    } result_t;

    localparam int NODES     = MAX_NODES_DEF;
    localparam int WDOG_LIMIT = 200000;
    localparam logic [TOTAL_WIDTH-1:0] TOTAL_SAT = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] cmd = CMD_CLEAR;
    logic [SYM_W-1:0] symbol = '0;
    logic last = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [TOTAL_WIDTH-1:0] match_total;
    logic status;
    logic text_done;

    multi_pattern_dna_match_counter_unit uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .cmd(cmd), .symbol(symbol), .last(last),
        .result_valid(result_valid), .result_stall(result_stall),
        .match_total(match_total), .status(status), .text_done(text_done)
    );

    always #2 clk = ~clk;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      quiet = 1'b0;

    // automaton state
    int unsigned trie_kid[NODES*ALPHABET];
    int unsigned fail_to[NODES];
    int unsigned hit_count[NODES];
    bit          ends_here[NODES];
    int unsigned node_count;
    int unsigned ins_at;
    int unsigned scan_at;
    logic [TOTAL_WIDTH-1:0] total_acc;
    bit          broken;

    function automatic void trie_clear();
        for (int a = 0; a < ALPHABET; a++)
            trie_kid[a] = 0;
        fail_to[0] = 0;
        hit_count[0] = 0;
        ends_here[0] = 0;
        node_count = 1;
        ins_at = 0;
        scan_at = 0;
        total_acc = '0;
        broken = 0;
    endfunction

    function automatic bit trie_insert(int unsigned s, bit l);
        int unsigned c;
        bit dropped;
        dropped = 0;
        if (!broken)
        begin
            c = trie_kid[ins_at*ALPHABET + s];
            if (c == 0)
            begin
                if (node_count >= NODES)
                begin
                    broken = 1;
                    dropped = 1;
                end
                else
                begin
                    c = node_count++;
                    for (int a = 0; a < ALPHABET; a++)
                        trie_kid[c*ALPHABET + a] = 0;
                    fail_to[c] = 0;
                    hit_count[c] = 0;
                    ends_here[c] = 0;
                    trie_kid[ins_at*ALPHABET + s] = c;
                end
            end
            if (!dropped)
                ins_at = c;
        end
        else
        begin
            dropped = 1;
        end
        if (l)
        begin
            if (!broken)
                ends_here[ins_at] = 1;
            ins_at = 0;
            broken = 0;
        end
        return dropped;
    endfunction

    function automatic void build_links();
        int unsigned bfs[$];
        int unsigned x, y, w, f, sum;
        fail_to[0] = 0;
        hit_count[0] = ends_here[0];
        bfs = {bfs, 0};
        while (bfs.size() > 0)
        begin
            x = bfs.pop_front();
            for (int a = 0; a < ALPHABET; a++)
            begin
                y = trie_kid[x*ALPHABET + a];
                if (y != 0)
                begin
                    f = 0;
                    if (x != 0)
                    begin
                        w = fail_to[x];
                        while (w != 0 && trie_kid[w*ALPHABET + a] == 0)
                            w = fail_to[w];
                        f = trie_kid[w*ALPHABET + a];
                        if (f == y)
                            f = 0;
                    end
                    fail_to[y] = f;
                    sum = ends_here[y] + hit_count[f];
                    hit_count[y] = (sum > 65535) ? 65535 : sum;
                    bfs = {bfs, y};
                end
            end
        end
    endfunction

    function automatic void scan_step(int unsigned s);
        int unsigned x;
        logic [TOTAL_WIDTH:0] sum;
        x = scan_at;
        while (x != 0 && trie_kid[x*ALPHABET + s] == 0)
            x = fail_to[x];
        if (trie_kid[x*ALPHABET + s] != 0)
            x = trie_kid[x*ALPHABET + s];
        scan_at = x;
        sum = {1'b0, total_acc} + hit_count[x];
        total_acc = sum[TOTAL_WIDTH] ? TOTAL_SAT : sum[TOTAL_WIDTH-1:0];
    endfunction

    function automatic result_t predict_match(item_t it);
        result_t r;
        r = '0;
        case (cmd_t'(it.cmd))
            CMD_CLEAR:   trie_clear();
            CMD_PATTERN: r.status = trie_insert(it.sym, it.lst);
            CMD_BUILD:   build_links();
            default:
            begin
                scan_step(it.sym);
                r.done = it.lst;
            end
        endcase
        r.total = total_acc;
        if (r.done)
        begin
            scan_at = 0;
            total_acc = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [TOTAL_WIDTH-1:0] got,
                                   logic [TOTAL_WIDTH-1:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    task automatic add_item(cmd_t c, int unsigned s, bit l);
        item_t it;
        it.cmd = c;
        it.sym = s[1:0];
        it.lst = l;
        pending_items = {pending_items, it};
    endtask

    // driver
    int item_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        item_t it;
        result_t exp_r;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_gap = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                exp_r = predict_match('{cmd, symbol, last});
                expected_results = {expected_results, exp_r};
            end
            if (!item_valid || !item_stall)
            begin
                if (item_gap > 0)
                begin
                    item_valid <= 1'b0;
                    item_gap--;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    cmd <= it.cmd;
                    symbol <= it.sym;
                    last <= it.lst;
                    item_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        item_gap = $urandom_range(1, 15);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor and result-side stalls
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected transaction", match_total, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (match_total !== want.total)
                        report_mismatch("match_total", match_total, want.total);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (text_done !== want.done)
                        report_mismatch("text_done", text_done, want.done);
                end
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("multi_pattern_dna_match_counter_unit: mismatch");
            $finish;
        end
    end

    function automatic int unsigned rand_base();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(0, 3);
    endfunction

    initial
    begin
        int n;
        int len;
        trie_clear();
        // directed
        add_item(CMD_CLEAR, 0, 0);
        add_item(CMD_PATTERN, 0, 1);
        add_item(CMD_PATTERN, 0, 0);
        add_item(CMD_PATTERN, 1, 1);
        add_item(CMD_PATTERN, 1, 0);
        add_item(CMD_PATTERN, 0, 1);
        add_item(CMD_PATTERN, 0, 1);
        add_item(CMD_PATTERN, 3, 0);
        add_item(CMD_PATTERN, 3, 1);
        add_item(CMD_TEXT, 0, 0);
        add_item(CMD_TEXT, 1, 1);
        add_item(CMD_BUILD, 0, 0);
        add_item(CMD_BUILD, 3, 1);
        add_item(CMD_TEXT, 0, 0);
        add_item(CMD_TEXT, 1, 0);
        add_item(CMD_TEXT, 0, 0);
        add_item(CMD_TEXT, 2, 0);
        add_item(CMD_TEXT, 3, 0);
        add_item(CMD_TEXT, 3, 1);
        add_item(CMD_PATTERN, 2, 1);
        add_item(CMD_TEXT, 2, 0);
        add_item(CMD_TEXT, 2, 1);
        add_item(CMD_BUILD, 0, 0);
        add_item(CMD_TEXT, 2, 1);
        add_item(CMD_CLEAR, 3, 1);
        n = 0;
        while (n < 1800)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 3),
                         $urandom_range(0, 1));
                n++;
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    add_item(CMD_CLEAR, $urandom_range(0, 3), $urandom_range(0, 1));
                    n++;
                end
                repeat ($urandom_range(1, 6))
                begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                        add_item(CMD_PATTERN, rand_base(), k == len - 1);
                    n += len;
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    add_item(CMD_BUILD, $urandom_range(0, 3), $urandom_range(0, 1));
                    n++;
                end
                len = $urandom_range(5, 40);
                for (int k = 0; k < len; k++)
                    add_item(CMD_TEXT, rand_base(), k == len - 1 && $urandom_range(0, 4) != 0);
                n += len;
            end
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_items.size() < 200);
        quiet = 1'b1;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (item_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("multi_pattern_dna_match_counter_unit: match");
        else
            $display("multi_pattern_dna_match_counter_unit: mismatch");
        $finish;
    end

endmodule
